/* design/osp_pkg.sv */
// osp_pkg: shared types, constants and the opcode classification table
// for the opcode stream predecoder. No dependencies.
`default_nettype none

package osp_pkg;

   localparam logic [15:0] RESET_START_ADDRESS = 16'h8000;
   localparam logic [15:0] RESET_MAX_INSTR     = 16'd5000;
   localparam logic [15:0] LAST_ADDRESS        = 16'hFFFF;

   localparam logic [5:0] KIND_NOP          = 6'd0;
   localparam logic [5:0] KIND_RTS          = 6'd12;
   localparam logic [5:0] KIND_BRANCH_FIRST = 6'd13;
   localparam logic [5:0] KIND_BRANCH_LAST  = 6'd19;

   localparam logic [1:0] LEN_NONE = 2'd0;
   localparam logic [1:0] LEN_WORD = 2'd2;

   // configuration register indexes
   localparam logic CSR_START_ADDRESS = 1'b0;
   localparam logic CSR_MAX_INSTR     = 1'b1;

   typedef enum logic [1:0] {
      PH_OPCODE = 2'd0,
      PH_LOW    = 2'd1,
      PH_HIGH   = 2'd2
   } phase_type;

   // classified program byte, front to back
   typedef struct packed {
      logic [7:0] code;
      logic       known;
      logic [5:0] kind;
      logic [1:0] len;
   } mid_type;

   // decoded instruction, back to result queue
   typedef struct packed {
      logic [5:0]  kind;
      logic [15:0] operand;
      logic [15:0] address;
      logic        unknown;
      logic        final_res;
   } rsp_type;

   // Opcode table: kind and operand length. Bytes that are not opcodes of the
   // subset come back with known low.
   function automatic mid_type classify(input logic [7:0] code);
      mid_type r;
      r.code  = code;
      r.known = 1'b1;
      r.kind  = KIND_NOP;
      r.len   = LEN_NONE;
      case (code)
         8'hEA: begin r.kind = 6'd0;  r.len = 2'd0; end
         8'hA9: begin r.kind = 6'd1;  r.len = 2'd1; end
         8'hAD: begin r.kind = 6'd2;  r.len = 2'd2; end
         8'hBD: begin r.kind = 6'd3;  r.len = 2'd2; end
         8'hA2: begin r.kind = 6'd4;  r.len = 2'd1; end
         8'hA0: begin r.kind = 6'd5;  r.len = 2'd1; end
         8'h8D: begin r.kind = 6'd6;  r.len = 2'd2; end
         8'h9D: begin r.kind = 6'd7;  r.len = 2'd2; end
         8'h8E: begin r.kind = 6'd8;  r.len = 2'd2; end
         8'h8C: begin r.kind = 6'd9;  r.len = 2'd2; end
         8'h4C: begin r.kind = 6'd10; r.len = 2'd2; end
         8'h20: begin r.kind = 6'd11; r.len = 2'd2; end
         8'h60: begin r.kind = 6'd12; r.len = 2'd0; end
         8'h80: begin r.kind = 6'd13; r.len = 2'd1; end
         8'hF0: begin r.kind = 6'd14; r.len = 2'd1; end
         8'hD0: begin r.kind = 6'd15; r.len = 2'd1; end
         8'h30: begin r.kind = 6'd16; r.len = 2'd1; end
         8'h10: begin r.kind = 6'd17; r.len = 2'd1; end
         8'hB0: begin r.kind = 6'd18; r.len = 2'd1; end
         8'h90: begin r.kind = 6'd19; r.len = 2'd1; end
         8'hC9: begin r.kind = 6'd20; r.len = 2'd1; end
         8'hE0: begin r.kind = 6'd21; r.len = 2'd1; end
         8'hC0: begin r.kind = 6'd22; r.len = 2'd1; end
         8'hE8: begin r.kind = 6'd23; r.len = 2'd0; end
         8'hC8: begin r.kind = 6'd24; r.len = 2'd0; end
         8'hCA: begin r.kind = 6'd25; r.len = 2'd0; end
         8'h88: begin r.kind = 6'd26; r.len = 2'd0; end
         8'hEE: begin r.kind = 6'd27; r.len = 2'd2; end
         8'hCE: begin r.kind = 6'd28; r.len = 2'd2; end
         8'h69: begin r.kind = 6'd29; r.len = 2'd1; end
         8'hE9: begin r.kind = 6'd30; r.len = 2'd1; end
         8'h29: begin r.kind = 6'd31; r.len = 2'd1; end
         8'h09: begin r.kind = 6'd32; r.len = 2'd1; end
         8'h49: begin r.kind = 6'd33; r.len = 2'd1; end
         8'h0A: begin r.kind = 6'd34; r.len = 2'd0; end
         8'h4A: begin r.kind = 6'd35; r.len = 2'd0; end
         8'h2A: begin r.kind = 6'd36; r.len = 2'd0; end
         8'h6A: begin r.kind = 6'd37; r.len = 2'd0; end
         8'hAA: begin r.kind = 6'd38; r.len = 2'd0; end
         8'h8A: begin r.kind = 6'd39; r.len = 2'd0; end
         8'hA8: begin r.kind = 6'd40; r.len = 2'd0; end
         8'h98: begin r.kind = 6'd41; r.len = 2'd0; end
         8'h9A: begin r.kind = 6'd42; r.len = 2'd0; end
         8'hBA: begin r.kind = 6'd43; r.len = 2'd0; end
         8'h48: begin r.kind = 6'd44; r.len = 2'd0; end
         8'h68: begin r.kind = 6'd45; r.len = 2'd0; end
         8'h08: begin r.kind = 6'd46; r.len = 2'd0; end
         8'h28: begin r.kind = 6'd47; r.len = 2'd0; end
         8'h18: begin r.kind = 6'd48; r.len = 2'd0; end
         8'h38: begin r.kind = 6'd49; r.len = 2'd0; end
         8'h58: begin r.kind = 6'd50; r.len = 2'd0; end
         8'h78: begin r.kind = 6'd51; r.len = 2'd0; end
         8'hB8: begin r.kind = 6'd52; r.len = 2'd0; end
         default: begin
            r.known = 1'b0;
         end
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

/* design/osp_fifo.sv */
// osp_fifo: small register queue with push/full and pop/empty sides.
// No package dependencies.
`default_nettype none

module osp_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

/* design/osp_front.sv */
// osp_front: accepts program bytes, classifies each against the opcode
// table and queues the classified beat for the back end. Uses osp_pkg, osp_fifo.
`default_nettype none

module osp_front #(
   parameter int DEPTH = 2
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            push,
   input  wire logic [7:0]      code_byte,
   output logic                 full,
   input  wire logic            pop,
   output osp_pkg::mid_type     mid,
   output logic                 mid_valid
);

   import osp_pkg::*;

   mid_type classified;
   logic    mid_empty;

   // every byte is classified; the back end decides whether it is an opcode
   assign classified = classify(code_byte);
   assign mid_valid  = !mid_empty;

   osp_fifo #(
      .WIDTH ($bits(mid_type)),
      .DEPTH (DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (classified),
      .full      (full),
      .pop       (pop),
      .pop_data  (mid),
      .empty     (mid_empty)
   );

endmodule

`default_nettype wire

/* design/osp_back.sv */
// osp_back: decode sequencer. Gathers operands, resolves branch targets,
// tracks addresses, limit and halt, and holds the configuration registers.
// Uses osp_pkg.
`default_nettype none

module osp_back (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire osp_pkg::mid_type mid,
   input  wire logic            mid_valid,
   output logic                 mid_pop,
   input  wire logic            out_full,
   output logic                 out_push,
   output osp_pkg::rsp_type     out_data,
   input  wire logic            csr_write,
   input  wire logic            csr_index,
   input  wire logic [15:0]     csr_data
);

   import osp_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [5:0]  pending_kind_ff, pending_kind_in;
   logic [1:0]  pending_len_ff, pending_len_in;
   logic [7:0]  operand_low_ff, operand_low_in;
   logic [15:0] opcode_address_ff, opcode_address_in;
   logic [15:0] byte_address_ff, byte_address_in;
   logic [15:0] decoded_count_ff, decoded_count_in;
   logic        halted_ff, halted_in;
   logic        started_ff, started_in;
   logic [15:0] start_address_ff, start_address_in;
   logic [15:0] max_instr_ff, max_instr_in;

   logic        take;
   logic        do_finish;
   logic [5:0]  fin_kind;
   logic [15:0] fin_operand;
   logic [15:0] fin_op_addr;
   logic [15:0] count_inc;
   logic        is_branch;
   logic [15:0] branch_target;

   assign take      = mid_valid && !out_full;
   assign mid_pop   = take;
   assign count_inc = decoded_count_ff + 16'd1;
   assign is_branch = (pending_kind_ff >= KIND_BRANCH_FIRST)
                      && (pending_kind_ff <= KIND_BRANCH_LAST);
   assign branch_target = opcode_address_ff + 16'd2 + {{8{mid.code[7]}}, mid.code};

   always_comb begin
      phase_in          = phase_ff;
      pending_kind_in   = pending_kind_ff;
      pending_len_in    = pending_len_ff;
      operand_low_in    = operand_low_ff;
      opcode_address_in = opcode_address_ff;
      byte_address_in   = byte_address_ff;
      decoded_count_in  = decoded_count_ff;
      halted_in         = halted_ff;
      started_in        = started_ff;
      start_address_in  = start_address_ff;
      max_instr_in      = max_instr_ff;
      do_finish         = 1'b0;
      fin_kind          = pending_kind_ff;
      fin_operand       = '0;
      fin_op_addr       = opcode_address_ff;
      out_push          = 1'b0;
      out_data          = '0;

      // bytes after a halt are consumed and dropped
      if (take && !halted_ff) begin
         started_in      = 1'b1;
         byte_address_in = byte_address_ff + 16'd1;
         case (phase_ff)
            PH_LOW: begin
               if (pending_len_ff == LEN_WORD) begin
                  operand_low_in = mid.code;
                  phase_in       = PH_HIGH;
               end else begin
                  do_finish   = 1'b1;
                  fin_operand = is_branch ? branch_target : {8'h00, mid.code};
               end
            end
            PH_HIGH: begin
               do_finish   = 1'b1;
               fin_operand = {mid.code, operand_low_ff};
            end
            default: begin
               opcode_address_in = byte_address_ff;
               if (!mid.known) begin
                  out_push          = 1'b1;
                  out_data.kind     = KIND_NOP;
                  out_data.address  = byte_address_ff;
                  out_data.unknown  = 1'b1;
                  out_data.final_res = (byte_address_ff == LAST_ADDRESS);
                  halted_in         = (byte_address_ff == LAST_ADDRESS);
                  phase_in          = PH_OPCODE;
               end else begin
                  pending_kind_in = mid.kind;
                  pending_len_in  = mid.len;
                  if (mid.len == LEN_NONE) begin
                     do_finish   = 1'b1;
                     fin_kind    = mid.kind;
                     fin_op_addr = byte_address_ff;
                  end else begin
                     operand_low_in = '0;
                     phase_in       = PH_LOW;
                  end
               end
            end
         endcase

         if (do_finish) begin
            decoded_count_in   = count_inc;
            out_push           = 1'b1;
            out_data.kind      = fin_kind;
            out_data.operand   = fin_operand;
            out_data.address   = fin_op_addr;
            // wrap: last byte at top of memory, or operand ran past it
            out_data.final_res = (count_inc >= max_instr_ff) || (fin_kind == KIND_RTS)
                                 || (byte_address_ff == LAST_ADDRESS)
                                 || (byte_address_ff < fin_op_addr);
            halted_in          = out_data.final_res;
            phase_in           = PH_OPCODE;
         end
      end

      if (csr_write) begin
         case (csr_index)
            CSR_START_ADDRESS: begin
               start_address_in = csr_data;
               if (!started_ff) begin
                  byte_address_in = csr_data;
               end
            end
            CSR_MAX_INSTR: begin
               max_instr_in = csr_data;
            end
            default: begin
               max_instr_in = max_instr_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_OPCODE;
         pending_kind_ff   <= '0;
         pending_len_ff    <= LEN_NONE;
         operand_low_ff    <= '0;
         opcode_address_ff <= '0;
         byte_address_ff   <= RESET_START_ADDRESS;
         decoded_count_ff  <= '0;
         halted_ff         <= 1'b0;
         started_ff        <= 1'b0;
         start_address_ff  <= RESET_START_ADDRESS;
         max_instr_ff      <= RESET_MAX_INSTR;
      end else begin
         phase_ff          <= phase_in;
         pending_kind_ff   <= pending_kind_in;
         pending_len_ff    <= pending_len_in;
         operand_low_ff    <= operand_low_in;
         opcode_address_ff <= opcode_address_in;
         byte_address_ff   <= byte_address_in;
         decoded_count_ff  <= decoded_count_in;
         halted_ff         <= halted_in;
         started_ff        <= started_in;
         start_address_ff  <= start_address_in;
         max_instr_ff      <= max_instr_in;
      end
   end

endmodule

`default_nettype wire

/* design/opcode_stream_predecoder.sv */
// opcode_stream_predecoder: byte-stream predecoder for a 6502 instruction subset.
//
// Input: program bytes in ascending address order on req_code_byte, one beat
// per cycle while req_full is low (push/full queue side). Results: one
// decoded instruction per completed opcode, unknown opcodes as flagged NOPs,
// read from the queue side (rsp_empty/rsp_pop).
// Configuration: csr_valid/csr_ready write port, index 0 start address,
// index 1 instruction limit; csr_ready is always high. Write only when idle.
// Throughput: one byte per cycle sustained; the front classifies each byte
// and queues it, the back sequencer consumes one queued byte per cycle
// while the result queue is not full. A result passes from the front queue
// through the sequencer into the result queue, whose head drives the rsp_
// ports and can be popped.
// Reset: queues empty, start address 0x8000, limit 5000, decoder expecting an
// opcode. After the final result (RTS, limit or address wrap) all later
// bytes are accepted and dropped until reset.
// Receiver stall: the result queue fills, the sequencer stops, the front
// queue fills and req_full rises; nothing is lost.
// Uses osp_pkg, osp_front, osp_back, osp_fifo.
`default_nettype none

module opcode_stream_predecoder #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [7:0]  req_code_byte,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [5:0]       rsp_instr_kind,
   output logic [15:0]      rsp_operand_value,
   output logic [15:0]      rsp_instr_address,
   output logic             rsp_unknown_opcode,
   output logic             rsp_final_res,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_data
);

   import osp_pkg::*;

   mid_type mid;
   logic    mid_valid;
   logic    mid_pop;
   logic    out_full;
   logic    out_push;
   rsp_type out_data;
   rsp_type rsp_head;

   assign csr_ready = 1'b1;

   osp_front #(
      .DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .code_byte (req_code_byte),
      .full      (req_full),
      .pop       (mid_pop),
      .mid       (mid),
      .mid_valid (mid_valid)
   );

   osp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .mid       (mid),
      .mid_valid (mid_valid),
      .mid_pop   (mid_pop),
      .out_full  (out_full),
      .out_push  (out_push),
      .out_data  (out_data),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   osp_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_data),
      .full      (out_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_head),
      .empty     (rsp_empty)
   );

   assign rsp_instr_kind     = rsp_head.kind;
   assign rsp_operand_value  = rsp_head.operand;
   assign rsp_instr_address  = rsp_head.address;
   assign rsp_unknown_opcode = rsp_head.unknown;
   assign rsp_final_res      = rsp_head.final_res;

   // sequencer never produces a result the result queue cannot take
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      out_push |-> !out_full)
      else $error("result produced while result queue full");

   // nothing follows a final result
   a_silent_after_final: assert property (@(posedge clock) disable iff (reset)
      (out_push && out_data.final_res) |=> !out_push)
      else $error("result after final result");

   // unknown opcodes leave as NOP with zero operand
   a_unknown_is_nop: assert property (@(posedge clock) disable iff (reset)
      (out_push && out_data.unknown)
      |-> (out_data.kind == KIND_NOP) && (out_data.operand == 16'd0))
      else $error("unknown opcode result not a clean NOP");

endmodule

`default_nettype wire

/* bench/predecode_checker.sv */
`timescale 1ns / 100ps
// predecode_checker: tracks program bytes and csr writes going into the predecoder,
// predicts each decoded instruction and checks the result queue beat by beat.
// Depends on osp_pkg for the result struct, phase codes and kind constants.

module predecode_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   input  wire logic        req_full,
   input  wire logic [7:0]  req_code_byte,
   input  wire logic        rsp_empty,
   input  wire logic        rsp_pop,
   input  wire logic [5:0]  rsp_instr_kind,
   input  wire logic [15:0] rsp_operand_value,
   input  wire logic [15:0] rsp_instr_address,
   input  wire logic        rsp_unknown_opcode,
   input  wire logic        rsp_final_res,
   input  wire logic        csr_valid,
   input  wire logic        csr_ready,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_data,
   input  wire logic        drain_done,
   output int               fail_count = 0,
   output int               open_results = 0,
   output int               results_checked = 0
);
   import osp_pkg::*;

   localparam int KIND_TOTAL = 53;

   // opcode per kind, kind 52 in the top byte down to kind 0 at the bottom
   localparam logic [8*KIND_TOTAL-1:0] OPCODE_BY_KIND = {
      8'hB8, 8'h78, 8'h58, 8'h38, 8'h18,
      8'h28, 8'h08, 8'h68, 8'h48, 8'hBA, 8'h9A, 8'h98, 8'hA8, 8'h8A, 8'hAA,
      8'h6A, 8'h2A, 8'h4A, 8'h0A, 8'h49, 8'h09, 8'h29, 8'hE9, 8'h69,
      8'hCE, 8'hEE, 8'h88, 8'hCA, 8'hC8, 8'hE8, 8'hC0, 8'hE0, 8'hC9,
      8'h90, 8'hB0, 8'h10, 8'h30, 8'hD0, 8'hF0, 8'h80, 8'h60, 8'h20, 8'h4C,
      8'h8C, 8'h8E, 8'h9D, 8'h8D, 8'hA0, 8'hA2, 8'hBD, 8'hAD, 8'hA9, 8'hEA
   };

   // operand length per kind, same ordering
   localparam logic [2*KIND_TOTAL-1:0] LEN_BY_KIND = {
      {19{2'd0}}, {5{2'd1}}, {2{2'd2}}, {4{2'd0}}, {10{2'd1}}, 2'd0,
      {6{2'd2}}, {2{2'd1}}, {2{2'd2}}, 2'd1, 2'd0
   };

   // newest prediction at the front, oldest at the back
   rsp_type     expected_instrs[$];
   logic [15:0] start_reg;
   logic [15:0] limit_reg;
   logic [15:0] next_addr;
   logic [15:0] op_addr;
   logic [15:0] known_count;
   phase_type   phase;
   logic [5:0]  pend_kind;
   logic [7:0]  low_byte;
   logic        halted;
   logic        started;
   logic        drain_seen;

   function automatic int kind_of(input logic [7:0] code);
      for (int k = 0; k < KIND_TOTAL; k++)
         if (OPCODE_BY_KIND[8*k +: 8] == code) return k;
      return -1;
   endfunction

   task automatic report(input string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      fail_count++;
   endtask

   task automatic compare_field(input string field, input logic [15:0] at,
                                input logic [15:0] seen, input logic [15:0] wanted);
      if (seen !== wanted)
         report($sformatf("%s of instr at 0x%04h: got 0x%0h, expected 0x%0h",
                          field, at, seen, wanted));
   endtask

   task automatic emit_known(input logic [5:0] kind, input logic [15:0] operand,
                             input logic [15:0] last_addr);
      rsp_type r;
      known_count = known_count + 16'd1;
      r.kind      = kind;
      r.operand   = operand;
      r.address   = op_addr;
      r.unknown   = 1'b0;
      // last byte below the opcode means the operand ran over 0xFFFF
      r.final_res = (known_count >= limit_reg) || (kind == KIND_RTS) ||
                    (last_addr == LAST_ADDRESS) || (last_addr < op_addr);
      expected_instrs.push_front(r);
      if (r.final_res) halted = 1'b1;
      phase = PH_OPCODE;
   endtask

   task automatic decode_byte(input logic [7:0] code);
      rsp_type     r;
      logic [15:0] here;
      int          k;
      if (!halted) begin
         started   = 1'b1;
         here      = next_addr;
         next_addr = here + 16'd1;
         case (phase)
            PH_LOW: begin
               if (LEN_BY_KIND[2*pend_kind +: 2] == LEN_WORD) begin
                  low_byte = code;
                  phase    = PH_HIGH;
               end else if (pend_kind >= KIND_BRANCH_FIRST && pend_kind <= KIND_BRANCH_LAST) begin
                  emit_known(pend_kind, op_addr + 16'd2 + {{8{code[7]}}, code}, here);
               end else begin
                  emit_known(pend_kind, {8'h00, code}, here);
               end
            end
            PH_HIGH: emit_known(pend_kind, {code, low_byte}, here);
            default: begin
               op_addr = here;
               k = kind_of(code);
               if (k < 0) begin
                  r.kind      = KIND_NOP;
                  r.operand   = 16'h0000;
                  r.address   = here;
                  r.unknown   = 1'b1;
                  r.final_res = (here == LAST_ADDRESS);
                  expected_instrs.push_front(r);
                  halted = r.final_res;
                  phase  = PH_OPCODE;
               end else begin
                  pend_kind = k[5:0];
                  if (LEN_BY_KIND[2*k +: 2] == LEN_NONE) begin
                     emit_known(pend_kind, 16'h0000, here);
                  end else begin
                     low_byte = 8'h00;
                     phase    = PH_LOW;
                  end
               end
            end
         endcase
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         start_reg   = RESET_START_ADDRESS;
         limit_reg   = RESET_MAX_INSTR;
         next_addr   = RESET_START_ADDRESS;
         op_addr     = 16'h0000;
         known_count = 16'h0000;
         phase       = PH_OPCODE;
         pend_kind   = KIND_NOP;
         low_byte    = 8'h00;
         halted      = 1'b0;
         started     = 1'b0;
         drain_seen  = 1'b0;
         expected_instrs.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_START_ADDRESS) begin
               start_reg = csr_data;
               if (!started) next_addr = csr_data;
            end else begin
               limit_reg = csr_data;
            end
         end
         if (req_push && !req_full) decode_byte(req_code_byte);
         if (rsp_pop && !rsp_empty) begin
            results_checked++;
            if (expected_instrs.size() == 0) begin
               report($sformatf("unexpected result kind %0d at 0x%04h",
                                rsp_instr_kind, rsp_instr_address));
            end else begin
               want = expected_instrs.pop_back();
               compare_field("kind", want.address, {10'd0, rsp_instr_kind}, {10'd0, want.kind});
               compare_field("operand", want.address, rsp_operand_value, want.operand);
               compare_field("address", want.address, rsp_instr_address, want.address);
               compare_field("unknown", want.address, {15'd0, rsp_unknown_opcode},
                             {15'd0, want.unknown});
               compare_field("final", want.address, {15'd0, rsp_final_res},
                             {15'd0, want.final_res});
            end
         end
         if (drain_done && !drain_seen) begin
            drain_seen = 1'b1;
            foreach (expected_instrs[i])
               report($sformatf("instr at 0x%04h never came out", expected_instrs[i].address));
         end
      end
      open_results <= expected_instrs.size();
   end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// tb_top: drives program bytes and csr phases into opcode_stream_predecoder with
// random push/pop gaps; predecode_checker does the prediction and comparison.
// Depends on osp_pkg, the design files and bench/predecode_checker.sv.

module tb_top;
   import osp_pkg::*;

   localparam int          CYCLE_LIMIT  = 400000;
   localparam int          PHASE_BYTES  = 420;
   localparam int          IDLE_PCT     = 14;
   localparam logic [15:0] WRAP_RUNWAY  = 16'hFFE0;

   localparam logic [7:0] OPC_NOP      = 8'hEA;
   localparam logic [7:0] OPC_LDA_IMM  = 8'hA9;
   localparam logic [7:0] OPC_LDA_ABS  = 8'hAD;
   localparam logic [7:0] OPC_JMP      = 8'h4C;
   localparam logic [7:0] OPC_RTS      = 8'h60;
   localparam logic [7:0] OPC_BRA      = 8'h80;
   localparam logic [7:0] OPC_BEQ      = 8'hF0;
   localparam logic [7:0] OPC_BNE      = 8'hD0;
   localparam logic [7:0] OPC_BPL      = 8'h10;
   localparam logic [7:0] OPC_TAX      = 8'hAA;
   localparam logic [7:0] OPC_CLV      = 8'hB8;
   localparam logic [7:0] OPC_BAD_LOW  = 8'h00;
   localparam logic [7:0] OPC_BAD_HIGH = 8'hFF;

   typedef enum int {
      STOP_RTS,
      STOP_LIMIT_EXACT,
      STOP_LIMIT_LOWERED,
      STOP_WRAP
   } stop_type;

   logic        clock         = 1'b0;
   logic        reset         = 1'b1;
   logic        req_push      = 1'b0;
   logic [7:0]  req_code_byte = 8'h00;
   logic        rsp_pop       = 1'b0;
   logic        csr_valid     = 1'b0;
   logic        csr_index     = CSR_START_ADDRESS;
   logic [15:0] csr_data      = 16'h0000;
   logic        drain_done    = 1'b0;
   wire         req_full;
   wire         rsp_empty;
   wire  [5:0]  rsp_instr_kind;
   wire  [15:0] rsp_operand_value;
   wire  [15:0] rsp_instr_address;
   wire         rsp_unknown_opcode;
   wire         rsp_final_res;
   wire         csr_ready;
   int          fail_count;
   int          open_results;
   int          results_checked;

   logic        calm        = 1'b0;
   logic [15:0] next_addr   = 16'h0000;
   int          bytes_sent  = 0;
   int          known_sent  = 0;
   int          cycle_count = 0;
   stop_type    stop_cause;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   opcode_stream_predecoder dut (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_code_byte      (req_code_byte),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_instr_kind     (rsp_instr_kind),
      .rsp_operand_value  (rsp_operand_value),
      .rsp_instr_address  (rsp_instr_address),
      .rsp_unknown_opcode (rsp_unknown_opcode),
      .rsp_final_res      (rsp_final_res),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   predecode_checker predict_check (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_code_byte      (req_code_byte),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_instr_kind     (rsp_instr_kind),
      .rsp_operand_value  (rsp_operand_value),
      .rsp_instr_address  (rsp_instr_address),
      .rsp_unknown_opcode (rsp_unknown_opcode),
      .rsp_final_res      (rsp_final_res),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .drain_done         (drain_done),
      .fail_count         (fail_count),
      .open_results       (open_results),
      .results_checked    (results_checked)
   );

   // receiver stalls at random, except in the calm stretch
   always @(posedge clock) begin
      if (reset) rsp_pop <= 1'b0;
      else rsp_pop <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, open_results);
         $display("tb_top failed");
         $finish;
      end
   end

   task automatic send_byte(input logic [7:0] code);
      while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push      <= 1'b1;
      req_code_byte <= code;
      @(posedge clock);
      while (req_full) @(posedge clock);
      bytes_sent++;
      next_addr = next_addr + 16'd1;
   endtask

   task automatic send_instr(input logic [7:0] opcode, input logic [15:0] operand);
      mid_type c;
      c = classify(opcode);
      send_byte(opcode);
      if (c.known) begin
         known_sent++;
         if (c.len != LEN_NONE) send_byte(operand[7:0]);
         if (c.len == LEN_WORD) send_byte(operand[15:8]);
      end
   endtask

   // RTS is held back for the end of the run since it stops decoding for good
   task automatic send_random_instr();
      mid_type     c;
      logic [7:0]  opcode;
      logic [15:0] operand;
      operand = 16'($urandom_range(0, 16'hFFFF));
      case ($urandom_range(0, 15))
         0: operand = 16'h0000;
         1: operand = 16'hFFFF;
         default: ;
      endcase
      if ($urandom_range(0, 99) < 15) begin
         do begin
            opcode = 8'($urandom_range(0, 255));
            c = classify(opcode);
         end while (c.known);
      end else begin
         do begin
            opcode = 8'($urandom_range(0, 255));
            c = classify(opcode);
         end while (!c.known || opcode == OPC_RTS);
      end
      send_instr(opcode, operand);
   endtask

   task automatic write_csr(input logic idx, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic drain_results();
      req_push <= 1'b0;
      @(posedge clock);
      while (open_results != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   initial begin
      logic [15:0] start_at;
      logic [15:0] wrap_target;
      logic [7:0]  wrap_opcode;
      int          phase_end;
      int          limit_at;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      stop_cause = stop_type'($urandom_range(0, 3));
      if (stop_cause == STOP_WRAP)
         start_at = WRAP_RUNWAY - 16'd1625 - 16'($urandom_range(0, 50));
      else if ($urandom_range(0, 3) == 0)
         start_at = 16'h0000;
      else
         start_at = 16'($urandom_range(0, 16'hE000));

      // extremes first; nothing has been decoded yet, so the last start wins
      write_csr(CSR_START_ADDRESS, 16'hFFFF);
      write_csr(CSR_MAX_INSTR, 16'h0001);
      write_csr(CSR_START_ADDRESS, 16'h0000);
      write_csr(CSR_MAX_INSTR, 16'hFFFF);
      write_csr(CSR_START_ADDRESS, start_at);
      csr_valid <= 1'b0;
      next_addr = start_at;

      send_instr(OPC_NOP, 16'h0000);
      send_instr(OPC_LDA_IMM, 16'h0000);
      send_instr(OPC_LDA_IMM, 16'h00FF);
      send_instr(OPC_LDA_ABS, 16'h0000);
      send_instr(OPC_JMP, 16'hFFFF);
      send_instr(OPC_BEQ, 16'h0000);
      send_instr(OPC_BNE, 16'h007F);
      send_instr(OPC_BRA, 16'h0080);
      send_instr(OPC_BPL, 16'h00FF);
      send_instr(OPC_BAD_LOW, 16'h0000);
      send_instr(OPC_BAD_HIGH, 16'h0000);
      send_instr(OPC_TAX, 16'h0000);
      send_instr(OPC_CLV, 16'h0000);
      drain_results();

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: write_csr(CSR_MAX_INSTR, RESET_MAX_INSTR);
            1: write_csr(CSR_MAX_INSTR, 16'($urandom_range(4000, 65535)));
            2: write_csr(CSR_START_ADDRESS, 16'($urandom_range(0, 16'hFFFF)));
            default: write_csr(CSR_MAX_INSTR, 16'hFFFF);
         endcase
         csr_valid <= 1'b0;
         calm = (ph == 1);
         phase_end = bytes_sent + PHASE_BYTES;
         while (bytes_sent < phase_end &&
                !(stop_cause == STOP_WRAP && next_addr >= WRAP_RUNWAY))
            send_random_instr();
         calm = 1'b0;
         drain_results();
      end

      case (stop_cause)
         STOP_RTS: begin
            repeat ($urandom_range(0, 20)) send_random_instr();
            send_instr(OPC_RTS, 16'h0000);
         end
         STOP_LIMIT_EXACT, STOP_LIMIT_LOWERED: begin
            if (stop_cause == STOP_LIMIT_EXACT) begin
               limit_at = known_sent + $urandom_range(1, 20);
               write_csr(CSR_MAX_INSTR, 16'(limit_at));
            end else begin
               // limit below the count: the next known instruction ends it
               limit_at = known_sent + 1;
               write_csr(CSR_MAX_INSTR, 16'h0001);
            end
            csr_valid <= 1'b0;
            while (known_sent < limit_at) send_random_instr();
         end
         default: begin
            case ($urandom_range(0, 5))
               0: begin wrap_target = 16'hFFFF; wrap_opcode = OPC_NOP;     end
               1: begin wrap_target = 16'hFFFF; wrap_opcode = OPC_BAD_LOW; end
               2: begin wrap_target = 16'hFFFE; wrap_opcode = OPC_LDA_IMM; end
               3: begin wrap_target = 16'hFFFD; wrap_opcode = OPC_JMP;     end
               // operand straddles the top of memory
               4: begin wrap_target = 16'hFFFE; wrap_opcode = OPC_JMP;     end
               default: begin wrap_target = 16'hFFFF; wrap_opcode = OPC_BEQ; end
            endcase
            while (next_addr != wrap_target) send_instr(OPC_NOP, 16'h0000);
            send_instr(wrap_opcode, 16'($urandom_range(0, 16'hFFFF)));
         end
      endcase

      // decoder has stopped; these beats must produce nothing
      repeat (20) send_byte(8'($urandom_range(0, 255)));
      drain_results();
      drain_done <= 1'b1;
      repeat (2) @(posedge clock);

      $display("covered %0d program bytes (%0d known opcodes), %0d decoded results checked",
               bytes_sent, known_sent, results_checked);
      $display("decoding stop reason exercised: %s", stop_cause.name());
      if (fail_count == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

endmodule
